FILE: design/tsls_pkg.sv
package tsls_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned TTI_W      = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned LEVELS_DEF = 10;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(6068);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(60681);
  localparam logic [SIZE_W-1:0] SNAP     = SIZE_W'(164);
  localparam logic [CFG_W-1:0]  IT_RESET = CFG_W'(900);

  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

endpackage

FILE: design/tti_square_level_smoother_core.sv
// time-to-indication square size smoother
// input channel: in_valid / in_stall with in_action, in_tti_centis, in_visible.
//   a set transaction (action 0) updates the shown flag and the target size,
//   a tick transaction (action 1) moves the smoothed size halfway to the target, or snaps to it when close.
// result channel: out_valid / out_stall with out_active, out_square_size,
//   out_redraw; every input transaction gives exactly one result transaction.
// config channel: cfg_valid / cfg_ready with cfg_data, the indication time
//   in centiseconds; cfg_ready is always high, write only while idle.
// a transaction is taken into the input register, processed from there into
//   the result register, and taken from the result register by the receiver.
// throughput: one transaction per cycle unless out_stall holds the result;
//   state is read and written by the logic between the input register and the result register.
// the receiver may hold out_stall as long as it likes: the result register
//   holds its value, the input register fills, then in_stall rises.
// reset (rst_n low, synchronous): indication time 900, square hidden,
//   sizes at the minimum, ticking enabled, both registers empty.
module tti_square_level_smoother_core #(
  parameter int unsigned LEVELS = tsls_pkg::LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [tsls_pkg::TTI_W-1:0]   in_tti_centis,
  input  logic                                in_visible,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_active,
  output logic        [tsls_pkg::SIZE_W-1:0]  out_square_size,
  output logic                                out_redraw,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [tsls_pkg::CFG_W-1:0]   cfg_data
);
  import tsls_pkg::*;

  localparam int unsigned KW   = $clog2(LEVELS);
  localparam int unsigned PW   = CFG_W + $clog2(LEVELS + 1);
  localparam int unsigned SPAN = 32'(MAX_SIZE) - 32'(MIN_SIZE);
  localparam int unsigned DEN  = LEVELS - 1;

  // size table indexed by k, the bin count below the time
  logic [SIZE_W-1:0] lvl_tab [LEVELS];

  for (genvar g = 0; g < LEVELS; g++) begin : g_tab
    localparam int unsigned IDX = LEVELS - 1 - g;
    localparam int unsigned LV  = 32'(MIN_SIZE) + (IDX * SPAN + DEN / 2) / DEN;
    assign lvl_tab[g] = SIZE_W'(LV);
  end

  logic [CFG_W-1:0]        it_r;
  logic                    s1_vld_r;
  logic                    s1_act_r;
  logic signed [TTI_W-1:0] s1_tti_r;
  logic                    s1_vis_r;
  logic                    shown_r, shown_nxt;
  logic [SIZE_W-1:0]       smooth_r, smooth_nxt;
  logic [SIZE_W-1:0]       target_r, target_nxt;
  logic                    ticking_r, ticking_nxt;
  logic                    redraw_nxt;
  logic                    out_vld_r;
  logic                    out_act_r;
  logic [SIZE_W-1:0]       out_size_r;
  logic                    out_redraw_r;
  logic                    adv;
  logic                    in_take;
  logic                    req;
  logic                    in_bin;
  logic [PW-1:0]           tti_scaled;
  logic [KW-1:0]           k;
  logic signed [SIZE_W:0]  d;
  logic signed [SIZE_W:0]  snap_s;
  logic signed [SIZE_W:0]  sum;

  assign cfg_ready = 1'b1;
  assign adv       = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !adv;
  assign in_take   = in_valid && !in_stall;

  // bin count: how many of the thresholds j*T lie at or below tti*LEVELS
  assign tti_scaled = PW'(s1_tti_r[CFG_W-1:0]) * PW'(LEVELS);

  always_comb begin
    k = '0;
    for (int j = 1; j < LEVELS; j++) begin
      if (PW'(it_r) * PW'(j) <= tti_scaled) k = k + KW'(1);
    end
  end

  assign snap_s = (SIZE_W+1)'(SNAP);
  assign d      = $signed({1'b0, target_r}) - $signed({1'b0, smooth_r});
  assign sum    = $signed({1'b0, smooth_r}) + (d >>> 1);

  always_comb begin
    req         = s1_vis_r;
    in_bin      = !s1_tti_r[TTI_W-1] && (s1_tti_r[TTI_W-2:0] < (TTI_W-1)'(it_r));
    shown_nxt   = shown_r;
    smooth_nxt  = smooth_r;
    target_nxt  = target_r;
    ticking_nxt = ticking_r;
    redraw_nxt  = 1'b0;
    if (s1_act_r == ACT_SET) begin
      if (s1_tti_r > $signed({{(TTI_W-CFG_W){1'b0}}, it_r})) req = 1'b0;
      if (shown_r != req) begin
        shown_nxt  = req;
        smooth_nxt = MIN_SIZE;
        redraw_nxt = 1'b1;
      end
      if (req) begin
        ticking_nxt = 1'b1;
        if (in_bin) target_nxt = lvl_tab[k];
      end
    end else if (ticking_r) begin
      if (d < snap_s && d > -snap_s) begin
        smooth_nxt  = target_r;
        ticking_nxt = 1'b0;
      end else begin
        smooth_nxt = sum[SIZE_W-1:0];
        redraw_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r      <= IT_RESET;
      s1_vld_r  <= 1'b0;
      shown_r   <= 1'b0;
      smooth_r  <= MIN_SIZE;
      target_r  <= MIN_SIZE;
      ticking_r <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) it_r <= cfg_data;
      if (in_take) s1_vld_r <= 1'b1;
      else if (adv) s1_vld_r <= 1'b0;
      if (adv) begin
        shown_r   <= shown_nxt;
        smooth_r  <= smooth_nxt;
        target_r  <= target_nxt;
        ticking_r <= ticking_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_act_r <= in_action;
      s1_tti_r <= in_tti_centis;
      s1_vis_r <= in_visible;
    end
    if (adv) begin
      out_act_r    <= shown_nxt;
      out_size_r   <= smooth_nxt;
      out_redraw_r <= redraw_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_active      = out_act_r;
  assign out_square_size = out_size_r;
  assign out_redraw      = out_redraw_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_act_r == ACT_TICK && !ticking_r) |=> $stable(smooth_r))
    else $error("tick changed size while ticking was stopped");

  a_show_change_min: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_act_r == ACT_SET && shown_nxt != shown_r) |=> smooth_r == MIN_SIZE)
    else $error("shown change did not restart the size at the minimum");

  a_snap_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ticking_r) |-> smooth_r == target_r)
    else $error("ticking stopped away from the target");
`endif

endmodule

FILE: bench/tb_tti_square_level_smoother_core.sv
module tb_tti_square_level_smoother_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLEV    = tsls_pkg::LEVELS_DEF;
  localparam int MIN_SZ  = int'(tsls_pkg::MIN_SIZE);
  localparam int MAX_SZ  = int'(tsls_pkg::MAX_SIZE);
  localparam int SNAP_SZ = int'(tsls_pkg::SNAP);
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic                           active;
    logic [tsls_pkg::SIZE_W-1:0]    size;
    logic                           redraw;
  } square_result_t;

  // tracks the indicator state and keeps the results still owed by the block
  class square_size_tracker;
    logic [tsls_pkg::CFG_W-1:0]  limit;
    logic                        shown;
    logic [tsls_pkg::SIZE_W-1:0] smooth;
    logic [tsls_pkg::SIZE_W-1:0] target;
    logic                        ticking;
    square_result_t              owed_results[$];
    int                          errors;

    function new();
      limit   = tsls_pkg::IT_RESET;
      shown   = 1'b0;
      smooth  = tsls_pkg::MIN_SIZE;
      target  = tsls_pkg::MIN_SIZE;
      ticking = 1'b1;
      errors  = 0;
    endfunction

    function logic [tsls_pkg::SIZE_W-1:0] bin_size(int n);
      int span;
      span = MAX_SZ - MIN_SZ;
      return tsls_pkg::SIZE_W'(MIN_SZ + ((n - 1) * span + (NLEV - 1) / 2) / (NLEV - 1));
    endfunction

    function void note_item(logic act, logic signed [tsls_pkg::TTI_W-1:0] tti, logic vis);
      int t;
      int lim;
      int k;
      int gap;
      logic req;
      logic redraw;
      square_result_t r;
      redraw = 1'b0;
      if (act == tsls_pkg::ACT_SET) begin
        t = tti;
        lim = int'(limit);
        req = vis;
        if (t > lim) req = 1'b0;
        if (shown != req) begin
          shown = req;
          smooth = tsls_pkg::MIN_SIZE;
          redraw = 1'b1;
        end
        if (shown) begin
          ticking = 1'b1;
          if (t >= 0 && t < lim) begin
            k = (t * NLEV) / lim;
            target = bin_size(NLEV - k);
          end
        end
      end else if (ticking) begin
        gap = int'(target) - int'(smooth);
        if (gap < SNAP_SZ && gap > -SNAP_SZ) begin
          smooth = target;
          ticking = 1'b0;
        end else begin
          // arithmetic shift rounds toward minus infinity
          smooth = smooth + tsls_pkg::SIZE_W'(gap >>> 1);
          redraw = 1'b1;
        end
      end
      r.active = shown;
      r.size   = smooth;
      r.redraw = redraw;
      owed_results.push_back(r);
    endfunction

    function void check_result(logic act_out, logic [tsls_pkg::SIZE_W-1:0] size_out,
                               logic redraw_out);
      square_result_t r;
      if (owed_results.size() == 0) begin
        $display("%0t: result transaction with none expected: active %0b size %0d redraw %0b",
                 $time, act_out, size_out, redraw_out);
        errors++;
        return;
      end
      r = owed_results.pop_front();
      if (act_out !== r.active) begin
        $display("%0t: active expected %0b actual %0b", $time, r.active, act_out);
        errors++;
      end
      if (size_out !== r.size) begin
        $display("%0t: square_size expected %0d actual %0d", $time, r.size, size_out);
        errors++;
      end
      if (redraw_out !== r.redraw) begin
        $display("%0t: redraw expected %0b actual %0b", $time, r.redraw, redraw_out);
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_action;
  logic signed [tsls_pkg::TTI_W-1:0]   in_tti_centis;
  logic                                in_visible;
  logic                                out_valid;
  logic                                out_stall;
  logic                                out_active;
  logic        [tsls_pkg::SIZE_W-1:0]  out_square_size;
  logic                                out_redraw;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic        [tsls_pkg::CFG_W-1:0]   cfg_data;

  square_size_tracker tracker = new();
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  tti_square_level_smoother_core #(.LEVELS(NLEV)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_tti_centis   (in_tti_centis),
    .in_visible      (in_visible),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_active      (out_active),
    .out_square_size (out_square_size),
    .out_redraw      (out_redraw),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result(out_active, out_square_size, out_redraw);
      if (in_valid && !in_stall)
        tracker.note_item(in_action, in_tti_centis, in_visible);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // starts and ends at a falling edge; valid stays high for a following transaction
  task automatic send_item(logic act, logic signed [tsls_pkg::TTI_W-1:0] tti, logic vis);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_tti_centis <= tti;
    in_visible    <= vis;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_results(int max_cycles);
    int n;
    n = 0;
    while (tracker.owed_results.size() != 0 && n < max_cycles) begin
      @(negedge clk);
      n++;
    end
  endtask

  task automatic write_limit(logic [tsls_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    wait_results(20000);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [tsls_pkg::TTI_W-1:0] pick_tti(int lim);
    int r;
    int sel;
    r = $urandom_range(0, 99);
    if (r < 70) return tsls_pkg::TTI_W'($urandom_range(0, lim));
    if (r < 85) begin
      sel = $urandom_range(0, 4);
      case (sel)
        0:       return -16'sd1;
        1:       return '0;
        2:       return tsls_pkg::TTI_W'(lim - 1);
        3:       return tsls_pkg::TTI_W'(lim);
        default: return tsls_pkg::TTI_W'(lim + 1);
      endcase
    end
    return tsls_pkg::TTI_W'($urandom);
  endfunction

  // mostly a set transaction followed by a run of ticks, some loose noise
  task automatic run_random(int count);
    int sent;
    int ticks;
    int lim;
    sent = 0;
    lim = int'(tracker.limit);
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item(tsls_pkg::ACT_SET, pick_tti(lim), $urandom_range(0, 9) != 0);
        ticks = $urandom_range(1, 8);
        repeat (ticks) send_item(tsls_pkg::ACT_TICK, tsls_pkg::TTI_W'($urandom), 1'($urandom));
        sent += ticks + 1;
      end else begin
        send_item(1'($urandom), tsls_pkg::TTI_W'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [tsls_pkg::CFG_W-1:0] limits[7];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = tsls_pkg::ACT_SET;
    in_tti_centis = '0;
    in_visible    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    limits = '{13'd0, 13'd1, 13'd8191, 13'd6000, 13'd10,
               tsls_pkg::CFG_W'($urandom_range(2, 8190)), tsls_pkg::IT_RESET};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit of 900
    send_item(tsls_pkg::ACT_TICK, '0, 1'b0);        // snaps at once after reset
    send_item(tsls_pkg::ACT_TICK, '0, 1'b0);        // timer stopped
    send_item(tsls_pkg::ACT_SET, 16'sd0, 1'b1);     // top bin, largest size
    repeat (4) send_item(tsls_pkg::ACT_TICK, '0, 1'b0);
    send_item(tsls_pkg::ACT_SET, 16'sd899, 1'b1);   // lowest bin
    send_item(tsls_pkg::ACT_TICK, '0, 1'b0);
    send_item(tsls_pkg::ACT_SET, 16'sd900, 1'b1);   // equal to limit
    send_item(tsls_pkg::ACT_SET, 16'sd901, 1'b1);   // above limit hides
    send_item(tsls_pkg::ACT_TICK, '0, 1'b0);        // hidden, still ticking
    send_item(tsls_pkg::ACT_SET, -16'sd32768, 1'b1);
    send_item(tsls_pkg::ACT_SET, 16'sd32767, 1'b1);
    send_item(tsls_pkg::ACT_SET, 16'sd450, 1'b0);
    send_item(tsls_pkg::ACT_SET, 16'sd450, 1'b1);
    send_item(tsls_pkg::ACT_TICK, -16'sd1, 1'b1);   // ignored fields all ones
    send_item(tsls_pkg::ACT_TICK, '0, 1'b0);
    send_item(tsls_pkg::ACT_SET, -16'sd1, 1'b1);
    send_item(tsls_pkg::ACT_SET, 16'sd1, 1'b1);
    repeat (3) send_item(tsls_pkg::ACT_TICK, '0, 1'b0);

    foreach (limits[i]) begin
      write_limit(limits[i]);
      if (i == 3) begin
        run_random(40);
        // long receiver hold while the sender keeps offering
        hold_req = 1'b1;
        run_random(40);
        // sender pauses until the block has drained
        in_valid <= 1'b0;
        @(negedge clk);
        wait_results(20000);
        run_random(50);
      end else begin
        if (i == 6) idle_en = 1'b0;
        run_random(125);
      end
    end

    in_valid <= 1'b0;
    wait_results(20000);
    repeat (8) @(negedge clk);
    if (tracker.owed_results.size() != 0)
      $display("%0t: %0d result transactions never arrived", $time,
               tracker.owed_results.size());
    if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
